### rtl/htbd_pkg.sv
// Shared types, constants and codes of the Huffman tree bit decoder.
`default_nettype none

package htbd_pkg;

  // Tree sizing.
  localparam int NUM_SYMBOLS  = 256;
  localparam int MAX_CODE_LEN = 32;
  localparam int NODE_DEPTH   = 2 * NUM_SYMBOLS;
  localparam int IDX_W        = $clog2(NODE_DEPTH);
  localparam int CNT_W        = IDX_W + 1;

  // Field widths.
  localparam int SYM_W      = 8;
  localparam int CODE_W     = 32;
  localparam int CODE_IDX_W = $clog2(CODE_W);
  localparam int LEN_W      = 6;
  localparam int LEN_CMP_W  = LEN_W + 1;

  // Command queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Operation codes on the op input.
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_DECODE = 2'd2
  } op_t;

  // Status codes of a result.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_PATH = 2'd1,
    ST_FAIL    = 2'd2
  } status_t;

  // Command class as decided by the front end.
  typedef enum logic [2:0] {
    K_NOP        = 3'd0,
    K_CLEAR      = 3'd1,
    K_LOAD       = 3'd2,
    K_LOAD_EMPTY = 3'd3,
    K_LOAD_LONG  = 3'd4,
    K_DECODE     = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic              sbit;
  } cmd_t;

  // One tree node: child valid bits, child indexes (0 = left, 1 = right), symbol.
  typedef struct packed {
    logic [1:0]            has;
    logic [1:0][IDX_W-1:0] child;
    logic [SYM_W-1:0]      sym;
  } node_t;

  localparam int    NODE_W     = $bits(node_t);
  localparam node_t NODE_EMPTY = '0;

endpackage

`default_nettype wire

### rtl/htbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module htbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/htbd_front.sv
// Front end: accepts input beats and classifies them into queue commands.
`default_nettype none

module htbd_front import htbd_pkg::*; (
  input  wire logic              start,
  input  wire logic [1:0]        op,
  input  wire logic [SYM_W-1:0]  symbol,
  input  wire logic [CODE_W-1:0] code_bits,
  input  wire logic [LEN_W-1:0]  code_length,
  input  wire logic              stream_bit,
  input  wire logic              q_full,
  output logic                   busy,
  output logic                   push,
  output cmd_t                   cmd
);

  logic code_long;

  // A beat is taken whenever the queue has room.
  assign busy = q_full;
  assign push = start && !q_full;

  assign code_long = LEN_CMP_W'(code_length) > LEN_CMP_W'(MAX_CODE_LEN);

  // Sort the beat into a command class; every class goes on to the back end.
  always_comb begin
    cmd.sym  = symbol;
    cmd.code = code_bits;
    cmd.len  = code_length;
    cmd.sbit = stream_bit;
    case (op)
      OP_CLEAR: begin
        cmd.kind = K_CLEAR;
      end
      OP_LOAD: begin
        if (code_length == '0) begin
          cmd.kind = K_LOAD_EMPTY;
        end else if (code_long) begin
          cmd.kind = K_LOAD_LONG;
        end else begin
          cmd.kind = K_LOAD;
        end
      end
      OP_DECODE: begin
        cmd.kind = K_DECODE;
      end
      default: begin
        cmd.kind = K_NOP;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/htbd_queue.sv
// Short command queue that decouples the front end from the back end.
`default_nettype none

module htbd_queue import htbd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output logic      full,
  output logic      empty
);

  cmd_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full  = count == (QUEUE_AW + 1)'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Payload storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

### rtl/htbd_back.sv
// Back end: walks and builds the node table and produces one result per command.
`default_nettype none

module htbd_back import htbd_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire cmd_t         head,
  input  wire logic         q_empty,
  output logic              pop,
  output logic              done,
  output logic              symbol_valid,
  output logic [SYM_W-1:0]  symbol_out,
  output status_t           status
);

  typedef enum logic [4:0] {
    S_IDLE      = 5'b00001,
    S_LD_STEP   = 5'b00010,
    S_LD_FETCH  = 5'b00100,
    S_DEC_CHILD = 5'b01000,
    S_DEC_LEAF  = 5'b10000
  } state_t;

  state_t            state, state_next;
  node_t             root, root_next;
  logic [CNT_W-1:0]  node_count, node_count_next;
  logic [IDX_W-1:0]  current_node, current_node_next;

  // Working registers of a load walk.
  logic [IDX_W-1:0]  cur_idx, cur_idx_next;
  node_t             cur_ent, cur_ent_next;
  logic [LEN_W-1:0]  bit_idx, bit_idx_next;
  logic [SYM_W-1:0]  sym_r, sym_r_next;
  logic [CODE_W-1:0] code_r, code_r_next;
  logic [LEN_W-1:0]  len_r, len_r_next;
  logic              sbit_r, sbit_r_next;

  // Result register.
  logic              done_next;
  logic              res_valid_next;
  logic [SYM_W-1:0]  res_sym_next;
  status_t           res_status_next;

  // Node table port signals.
  logic              wb_en;
  logic [IDX_W-1:0]  wb_idx;
  node_t             wb_ent;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_raddr;
  logic [NODE_W-1:0] ram_rdata;
  node_t             rd_ent;
  node_t             dec_ent;
  node_t             grown;

  logic              code_bit;
  logic              table_full;
  logic [IDX_W-1:0]  fresh;

  // The root lives in flip-flops; the rest of the tree lives in the RAM.
  assign ram_we = wb_en && (wb_idx != '0);

  htbd_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODE_DEPTH)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wb_idx),
    .wdata (wb_ent),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_ent  = node_t'(ram_rdata);
  assign dec_ent = (current_node == '0) ? root : rd_ent;

  // Code bit of the current load step; bits past the code word read as zero.
  assign code_bit = ({1'b0, bit_idx} < LEN_CMP_W'(CODE_W)) ?
                    code_r[bit_idx[CODE_IDX_W-1:0]] : 1'b0;

  assign table_full = node_count >= CNT_W'(NODE_DEPTH);
  assign fresh      = node_count[IDX_W-1:0];

  // Current node with a new child hung on the code bit.
  always_comb begin
    grown                  = cur_ent;
    grown.has[code_bit]    = 1'b1;
    grown.child[code_bit]  = fresh;
  end

  // Command sequencer.
  always_comb begin
    state_next        = state;
    root_next         = root;
    node_count_next   = node_count;
    current_node_next = current_node;
    cur_idx_next      = cur_idx;
    cur_ent_next      = cur_ent;
    bit_idx_next      = bit_idx;
    sym_r_next        = sym_r;
    code_r_next       = code_r;
    len_r_next        = len_r;
    sbit_r_next       = sbit_r;
    done_next         = 1'b0;
    res_valid_next    = 1'b0;
    res_sym_next      = '0;
    res_status_next   = ST_OK;
    wb_en             = 1'b0;
    wb_idx            = cur_idx;
    wb_ent            = cur_ent;
    ram_raddr         = '0;
    pop               = 1'b0;

    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          case (head.kind)
            K_CLEAR: begin
              root_next         = NODE_EMPTY;
              node_count_next   = CNT_W'(1);
              current_node_next = '0;
              done_next         = 1'b1;
            end
            K_LOAD: begin
              cur_idx_next = '0;
              cur_ent_next = root;
              bit_idx_next = '0;
              sym_r_next   = head.sym;
              code_r_next  = head.code;
              len_r_next   = head.len;
              state_next   = S_LD_STEP;
            end
            K_LOAD_LONG: begin
              res_status_next = ST_FAIL;
              done_next       = 1'b1;
            end
            K_DECODE: begin
              ram_raddr   = current_node;
              sbit_r_next = head.sbit;
              state_next  = S_DEC_CHILD;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      // One code bit per visit; the working node is written back unless the walk moves to an existing child.
      S_LD_STEP: begin
        if (bit_idx == len_r) begin
          wb_en           = 1'b1;
          wb_ent.sym      = sym_r;
          done_next       = 1'b1;
          state_next      = S_IDLE;
        end else if (cur_ent.has[code_bit]) begin
          cur_idx_next = cur_ent.child[code_bit];
          ram_raddr    = cur_ent.child[code_bit];
          bit_idx_next = bit_idx + 1'b1;
          state_next   = S_LD_FETCH;
        end else if (table_full) begin
          wb_en           = 1'b1;
          res_status_next = ST_FAIL;
          done_next       = 1'b1;
          state_next      = S_IDLE;
        end else begin
          wb_en           = 1'b1;
          wb_ent          = grown;
          cur_idx_next    = fresh;
          cur_ent_next    = NODE_EMPTY;
          node_count_next = node_count + 1'b1;
          bit_idx_next    = bit_idx + 1'b1;
        end
      end

      S_LD_FETCH: begin
        cur_ent_next = rd_ent;
        state_next   = S_LD_STEP;
      end

      // Follow the bit from the current node, falling back to the root.
      S_DEC_CHILD: begin
        if (dec_ent.has[sbit_r]) begin
          current_node_next = dec_ent.child[sbit_r];
          ram_raddr         = dec_ent.child[sbit_r];
          state_next        = S_DEC_LEAF;
        end else if (root.has[sbit_r]) begin
          current_node_next = root.child[sbit_r];
          ram_raddr         = root.child[sbit_r];
          state_next        = S_DEC_LEAF;
        end else begin
          current_node_next = '0;
          res_status_next   = ST_NO_PATH;
          done_next         = 1'b1;
          state_next        = S_IDLE;
        end
      end

      // A node without children is a leaf and emits its symbol.
      S_DEC_LEAF: begin
        if (dec_ent.has == 2'b00) begin
          res_valid_next = 1'b1;
          res_sym_next   = dec_ent.sym;
        end
        done_next  = 1'b1;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Writes to node zero land in the root register.
    if (wb_en && (wb_idx == '0)) begin
      root_next = wb_ent;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      root         <= NODE_EMPTY;
      node_count   <= CNT_W'(1);
      current_node <= '0;
      done         <= 1'b0;
    end else begin
      state        <= state_next;
      root         <= root_next;
      node_count   <= node_count_next;
      current_node <= current_node_next;
      done         <= done_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_idx      <= cur_idx_next;
    cur_ent      <= cur_ent_next;
    bit_idx      <= bit_idx_next;
    sym_r        <= sym_r_next;
    code_r       <= code_r_next;
    len_r        <= len_r_next;
    sbit_r       <= sbit_r_next;
    symbol_valid <= res_valid_next;
    symbol_out   <= res_sym_next;
    status       <= res_status_next;
  end

endmodule

`default_nettype wire

### rtl/huffman_tree_bit_decoder_top.sv
// Top level of the Huffman tree bit decoder.
//
// Every accepted beat (start high while busy is low) yields exactly one result,
// shown for one cycle with done high; the receiver cannot stall, so results
// must be taken as they come. Beats enter a two-entry command queue and busy is
// high only while that queue is full. The back end runs one command at a time:
// clear, empty and overlong loads and unused op codes finish in the idle state;
// a decode makes two dependent reads of the node table (current node, then the
// child reached), or only the first when the bit has no path from the root;
// a load takes one step for each code bit that creates a node and a step plus a
// fetch of the node for each bit that follows an existing node, and ends with a
// step for the final symbol write. The result appears in the cycle
// after the back end finishes. No clearing pass is needed after reset: the root
// node is held in flip-flops and every other node is written when allocated.
`default_nettype none

module huffman_tree_bit_decoder_top import htbd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [1:0]        op,
  input  wire logic [SYM_W-1:0]  symbol,
  input  wire logic [CODE_W-1:0] code_bits,
  input  wire logic [LEN_W-1:0]  code_length,
  input  wire logic              stream_bit,
  output logic                   busy,
  output logic                   done,
  output logic                   symbol_valid,
  output logic [SYM_W-1:0]       symbol_out,
  output logic [1:0]             status
);

  logic    push;
  logic    pop;
  logic    q_full;
  logic    q_empty;
  cmd_t    push_cmd;
  cmd_t    head;
  status_t res_status;

  assign status = res_status;

  // Classify incoming beats.
  htbd_front u_front (
    .start       (start),
    .op          (op),
    .symbol      (symbol),
    .code_bits   (code_bits),
    .code_length (code_length),
    .stream_bit  (stream_bit),
    .q_full      (q_full),
    .busy        (busy),
    .push        (push),
    .cmd         (push_cmd)
  );

  // Decoupling queue.
  htbd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Tree engine and result register.
  htbd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_empty      (q_empty),
    .pop          (pop),
    .done         (done),
    .symbol_valid (symbol_valid),
    .symbol_out   (symbol_out),
    .status       (res_status)
  );

endmodule

`default_nettype wire

### rtl/htbd_checker.sv
// Port-level checker of the Huffman tree bit decoder and its bind to the top level.
`default_nettype none

module htbd_checker import htbd_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             done,
  input wire logic             symbol_valid,
  input wire logic [SYM_W-1:0] symbol_out,
  input wire logic [1:0]       status
);

  localparam int OUT_W = $clog2(QUEUE_DEPTH + 3);

  logic [OUT_W-1:0] out_cnt;

  // Beats accepted whose result has not been shown yet.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_cnt <= '0;
    end else begin
      out_cnt <= out_cnt + OUT_W'(start && !busy) - OUT_W'(done);
    end
  end

  // A decoded symbol always comes with a clean status.
  a_symbol_ok: assert property (@(posedge clk) disable iff (rst)
    done && symbol_valid |-> status == ST_OK)
    else $error("symbol reported with a non-ok status");

  // Without a symbol the symbol field reads as zero.
  a_no_symbol_zero: assert property (@(posedge clk) disable iff (rst)
    done && !symbol_valid |-> symbol_out == '0)
    else $error("symbol field not zero on a result without symbol");

  // No result is produced without an accepted beat behind it.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> out_cnt != '0)
    else $error("result without an outstanding beat");

  // Busy is only raised once the queue holds a full backlog.
  a_busy_backlog: assert property (@(posedge clk) disable iff (rst)
    busy |-> out_cnt >= OUT_W'(QUEUE_DEPTH))
    else $error("busy raised without a full backlog");

  // Queue, engine and result register bound the backlog.
  a_backlog_bound: assert property (@(posedge clk) disable iff (rst)
    out_cnt <= OUT_W'(QUEUE_DEPTH + 2))
    else $error("more beats outstanding than the design can hold");

endmodule

bind huffman_tree_bit_decoder_top htbd_checker u_checker (.*);

`default_nettype wire

### bench/tb_huffman_tree_bit_decoder_top.sv
// Self-checking testbench of the Huffman tree bit decoder: tree build, decode walk and errors.
`timescale 1ns / 100ps

module tb_huffman_tree_bit_decoder_top import htbd_pkg::*;;

  // The op input has one code without a meaning; the block must answer it with zeros.
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct {
    logic [1:0]        op;
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic              sbit;
    int unsigned       gap;
  } beat_t;

  typedef struct {
    logic             valid;
    logic [SYM_W-1:0] sym;
    status_t          st;
  } tree_answer_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [1:0]        op = OP_CLEAR;
  logic [SYM_W-1:0]  symbol = '0;
  logic [CODE_W-1:0] code_bits = '0;
  logic [LEN_W-1:0]  code_length = '0;
  logic              stream_bit = 1'b0;
  logic              busy;
  logic              done;
  logic              symbol_valid;
  logic [SYM_W-1:0]  symbol_out;
  logic [1:0]        status;

  huffman_tree_bit_decoder_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .op           (op),
    .symbol       (symbol),
    .code_bits    (code_bits),
    .code_length  (code_length),
    .stream_bit   (stream_bit),
    .busy         (busy),
    .done         (done),
    .symbol_valid (symbol_valid),
    .symbol_out   (symbol_out),
    .status       (status)
  );

  // Stimulus waiting to be driven, and answers waiting to come back.
  beat_t        beat_queue[$];
  tree_answer_t answers_due[$];
  beat_t        port_beat;
  int unsigned  idle_cycles = 0;
  int unsigned  err_count = 0;

  // Our own copy of the code tree.
  node_t             tree_mem [NODE_DEPTH];
  int unsigned       node_total;
  logic [IDX_W-1:0]  walk_at;

  // Code set planned by the stimulus generator.
  logic [CODE_W-1:0] plan_code [NUM_SYMBOLS];
  int unsigned       plan_len [NUM_SYMBOLS];
  int unsigned       plan_n = 0;
  int unsigned       idle_pct = 0;
  int unsigned       live_beats = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void tree_reset();
    tree_mem[0] = NODE_EMPTY;
    node_total = 1;
    walk_at = '0;
  endfunction

  // Walks a code from the root, creating missing nodes, and writes the symbol at its end.
  function automatic status_t grow_code(logic [SYM_W-1:0] sym_v, logic [CODE_W-1:0] code_v,
                                        logic [LEN_W-1:0] len_v);
    logic [IDX_W-1:0] at;
    logic             dir;
    at = '0;
    if (len_v == 0) return ST_OK;
    if (len_v > MAX_CODE_LEN) return ST_FAIL;
    for (int i = 0; i < int'(len_v); i++) begin
      dir = code_v[i];
      if (!tree_mem[at].has[dir]) begin
        if (node_total >= NODE_DEPTH) return ST_FAIL;
        tree_mem[node_total[IDX_W-1:0]] = NODE_EMPTY;
        tree_mem[at].has[dir] = 1'b1;
        tree_mem[at].child[dir] = node_total[IDX_W-1:0];
        node_total++;
      end
      at = tree_mem[at].child[dir];
    end
    tree_mem[at].sym = sym_v;
    return ST_OK;
  endfunction

  // Applies one accepted beat to the tree copy and returns the answer it must give.
  function automatic tree_answer_t apply_to_tree(beat_t b);
    tree_answer_t r;
    logic         found;
    r.valid = 1'b0;
    r.sym = '0;
    r.st = ST_OK;
    found = 1'b0;
    case (b.op)
      OP_CLEAR: begin
        tree_reset();
      end
      OP_LOAD: begin
        r.st = grow_code(b.sym, b.code, b.len);
      end
      OP_DECODE: begin
        if (tree_mem[walk_at].has[b.sbit]) begin
          walk_at = tree_mem[walk_at].child[b.sbit];
          found = 1'b1;
        end else if (tree_mem[0].has[b.sbit]) begin
          // Past a leaf or off the tree: the walk restarts at the root.
          walk_at = tree_mem[0].child[b.sbit];
          found = 1'b1;
        end else begin
          walk_at = '0;
          r.st = ST_NO_PATH;
        end
        if (found && tree_mem[walk_at].has == 2'b00) begin
          r.valid = 1'b1;
          r.sym = tree_mem[walk_at].sym;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Driver: predicts each accepted beat and presents the next one after its idle gap.
  always @(posedge clk) begin
    beat_t nxt;
    if (rst) begin
      start <= 1'b0;
      op <= OP_CLEAR;
      symbol <= '0;
      code_bits <= '0;
      code_length <= '0;
      stream_bit <= 1'b0;
      idle_cycles = 0;
      tree_reset();
    end else begin
      if (start && !busy) answers_due.push_back(apply_to_tree(port_beat));
      if (!start || !busy) begin
        if (beat_queue.size() > 0 && idle_cycles >= beat_queue[0].gap) begin
          nxt = beat_queue.pop_front();
          port_beat = nxt;
          op <= nxt.op;
          symbol <= nxt.sym;
          code_bits <= nxt.code;
          code_length <= nxt.len;
          stream_bit <= nxt.sbit;
          start <= 1'b1;
          idle_cycles = 0;
        end else begin
          start <= 1'b0;
          if (beat_queue.size() > 0) idle_cycles++;
        end
      end
    end
  end

  // Monitor: every result strobe is checked against the oldest answer due.
  always @(posedge clk) begin
    tree_answer_t e;
    if (!rst && done) begin
      if (answers_due.size() == 0) begin
        err_count++;
        $display("%0t ns: result with nothing expected (valid %0d, symbol %02h, status %0d)",
                 $time, symbol_valid, symbol_out, status);
      end else begin
        e = answers_due.pop_front();
        if (symbol_valid !== e.valid) begin
          err_count++;
          $display("%0t ns: symbol_valid expected %0d, got %0d", $time, e.valid, symbol_valid);
        end
        if (symbol_out !== e.sym) begin
          err_count++;
          $display("%0t ns: symbol_out expected %02h, got %02h", $time, e.sym, symbol_out);
        end
        if (status !== e.st) begin
          err_count++;
          $display("%0t ns: status expected %0d, got %0d", $time, e.st, status);
        end
      end
    end
  end

  task automatic push_beat(logic [1:0] op_v, logic [SYM_W-1:0] sym_v, logic [CODE_W-1:0] code_v,
                           logic [LEN_W-1:0] len_v, logic sbit_v);
    beat_t b;
    b.op = op_v;
    b.sym = sym_v;
    b.code = code_v;
    b.len = len_v;
    b.sbit = sbit_v;
    b.gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 3) : 0;
    beat_queue.push_back(b);
    // Spare ops and empty codes do nothing, so they are not counted.
    if (op_v != OP_SPARE && !(op_v == OP_LOAD && len_v == 0)) live_beats++;
  endtask

  task automatic push_decode(logic sbit_v);
    push_beat(OP_DECODE, SYM_W'($urandom), $urandom, LEN_W'($urandom), sbit_v);
  endtask

  task automatic push_load(logic [SYM_W-1:0] sym_v, logic [CODE_W-1:0] code_v,
                           logic [LEN_W-1:0] len_v);
    push_beat(OP_LOAD, sym_v, code_v, len_v, $urandom_range(0, 1) == 1);
  endtask

  task automatic push_clear();
    push_beat(OP_CLEAR, SYM_W'($urandom), $urandom, LEN_W'($urandom),
              $urandom_range(0, 1) == 1);
  endtask

  // Builds a prefix-free code set by splitting leaves, either shallowest first or at random.
  task automatic build_plan(int unsigned n, int unsigned lim, logic balanced);
    int unsigned pick;
    plan_n = 1;
    plan_code[0] = '0;
    plan_len[0] = 0;
    while (plan_n < n) begin
      if (balanced) begin
        pick = 0;
        for (int j = 1; j < plan_n; j++) if (plan_len[j] < plan_len[pick]) pick = j;
      end else begin
        pick = $urandom_range(0, plan_n - 1);
        for (int j = 0; j < plan_n && plan_len[pick] >= lim; j++) pick = j;
      end
      if (plan_len[pick] >= lim) break;
      plan_code[plan_n] = plan_code[pick] | (32'd1 << plan_len[pick]);
      plan_len[plan_n] = plan_len[pick] + 1;
      plan_len[pick]++;
      plan_n++;
    end
  endtask

  task automatic send_code(int unsigned k, int unsigned nbits);
    for (int i = 0; i < nbits; i++) push_decode(plan_code[k][i]);
  endtask

  // Noise: stray bits, spare ops, empty and overlong codes, overwrites, new paths and clears.
  task automatic push_noise();
    int unsigned k;
    case ($urandom_range(0, 6))
      0: push_decode($urandom_range(0, 1) == 1);
      1: push_beat(OP_SPARE, SYM_W'($urandom), $urandom, LEN_W'($urandom),
                   $urandom_range(0, 1) == 1);
      2: push_load(SYM_W'($urandom), $urandom, '0);
      3: push_load(SYM_W'($urandom), $urandom, LEN_W'($urandom_range(MAX_CODE_LEN + 1, 63)));
      4: begin
        if (plan_n == 0) begin
          push_decode($urandom_range(0, 1) == 1);
        end else begin
          k = $urandom_range(0, plan_n - 1);
          push_load(SYM_W'($urandom), plan_code[k], LEN_W'($urandom_range(1, plan_len[k])));
        end
      end
      5: push_load(SYM_W'($urandom), $urandom, LEN_W'($urandom_range(1, MAX_CODE_LEN)));
      default: push_clear();
    endcase
  endtask

  // One phase of well-formed traffic: load a code set, then decode a stream built from it.
  task automatic code_phase();
    int unsigned n;
    int unsigned k;
    int unsigned sel;
    if ($urandom_range(0, 9) != 0) push_clear();
    n = $urandom_range(2, 24);
    build_plan(n, ($urandom_range(0, 1) != 0) ? MAX_CODE_LEN : $urandom_range(5, 12),
               $urandom_range(0, 3) == 0);
    for (int j = 0; j < plan_n; j++) begin
      if ($urandom_range(0, 9) == 0) push_noise();
      push_load(SYM_W'($urandom), plan_code[j], LEN_W'(plan_len[j]));
    end
    for (int m = $urandom_range(8, 30); m > 0; m--) begin
      k = $urandom_range(0, plan_n - 1);
      sel = $urandom_range(0, 19);
      if (sel == 0) send_code(k, $urandom_range(0, plan_len[k] - 1));
      else if (sel == 1) push_noise();
      else send_code(k, plan_len[k]);
    end
  endtask

  // Long random codes until the node table runs out, then walks into the partial paths.
  task automatic fill_phase();
    logic [CODE_W-1:0] last_code;
    last_code = '0;
    push_clear();
    for (int j = 0; j < 22; j++) begin
      last_code = $urandom;
      if (j == 0) plan_code[0] = last_code;
      push_load(SYM_W'($urandom), last_code, LEN_W'(MAX_CODE_LEN));
    end
    plan_len[0] = MAX_CODE_LEN;
    plan_n = 1;
    send_code(0, MAX_CODE_LEN);
    for (int i = 0; i < MAX_CODE_LEN; i++) push_decode(last_code[i]);
    for (int i = 0; i < 20; i++) push_decode($urandom_range(0, 1) == 1);
  endtask

  // All symbols in a balanced tree, then one node that still fits and one that does not.
  task automatic full_tree_phase();
    push_clear();
    build_plan(NUM_SYMBOLS, MAX_CODE_LEN, 1'b1);
    for (int j = 0; j < plan_n; j++) push_load(SYM_W'($urandom), plan_code[j],
                                               LEN_W'(plan_len[j]));
    for (int m = 0; m < 20; m++) send_code($urandom_range(0, plan_n - 1), plan_len[0]);
    push_load(SYM_W'($urandom), plan_code[0], LEN_W'(plan_len[0] + 1));
    push_load(SYM_W'($urandom), plan_code[1], LEN_W'(plan_len[1] + 1));
    push_load(SYM_W'($urandom), plan_code[2], LEN_W'(plan_len[2]));
    send_code(0, plan_len[0]);
    push_decode(1'b0);
    send_code(1, plan_len[1]);
    send_code(2, plan_len[2]);
  endtask

  // Stimulus, reset and end of run.
  initial begin
    // Directed part on an empty tree, then a small hand-made tree.
    idle_pct = 0;
    push_decode(1'b0);
    push_decode(1'b1);
    push_beat(OP_SPARE, 8'hFF, 32'hFFFF_FFFF, 6'd63, 1'b1);
    push_load(8'hFF, 32'hFFFF_FFFF, 6'd0);
    push_load(8'h01, 32'h0, 6'd33);
    push_load(8'hFE, 32'hFFFF_FFFF, 6'd63);
    push_load(8'h5A, 32'h0, 6'd1);
    push_load(8'hFF, 32'hFFFF_FFFF, 6'd32);
    push_load(8'hC3, 32'h1, 6'd2);
    push_decode(1'b0);
    push_decode(1'b1);
    push_decode(1'b0);
    // Deep inside the all-ones path a zero bit has no child and restarts at the root.
    push_decode(1'b1);
    push_decode(1'b1);
    push_decode(1'b0);
    // Symbol written onto an inner node, then a load in the middle of a walk.
    push_load(8'h77, 32'h1, 6'd1);
    push_decode(1'b1);
    push_load(8'h11, 32'h2, 6'd2);
    push_decode(1'b0);
    push_decode(1'b0);
    push_decode(1'b1);
    push_clear();
    push_decode(1'b1);
    push_load(8'h00, 32'h0, 6'd32);
    push_decode(1'b0);

    // Random part, with idle bursts except in the last stretch.
    idle_pct = 20;
    fill_phase();
    full_tree_phase();
    while (live_beats < 950) begin
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 15;
        default: idle_pct = 40;
      endcase
      if ($urandom_range(0, 7) == 0) fill_phase();
      else code_phase();
    end
    idle_pct = 0;
    while (live_beats < 1100) code_phase();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (beat_queue.size() != 0 || start) @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (err_count == 0) begin
      $display("** huffman_tree_bit_decoder_top: PASSED **");
    end else begin
      $display("** huffman_tree_bit_decoder_top: FAILED **");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("** huffman_tree_bit_decoder_top: FAILED **");
    $finish;
  end

endmodule
